[hw/rtl/hfpr_pkg.sv]
// Shared constants for the header-framed packet receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package hfpr_pkg;

    localparam int BYTE_W          = 8;
    localparam int INDEX_W         = 4;
    localparam int SUM_W           = 12;
    localparam int PAYLOAD_LEN_DEF = 13;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h52;

endpackage

`default_nettype wire

[hw/rtl/hfpr_ram.sv]
// Simple dual-port payload store: one write port, one registered read port.
// Depends on hfpr_pkg for the default data width.
`default_nettype none

module hfpr_ram
    import hfpr_pkg::*;
#(
    parameter int DEPTH  = PAYLOAD_LEN_DEF,
    parameter int WIDTH  = BYTE_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/header_framed_packet_receiver_core.sv]
// Top level of the header-framed packet receiver: framing FSM and output register.
// Depends on hfpr_pkg and hfpr_ram.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| payload_byte, byte_index, last_of_frame, frame_sum
//
// Header bytes feed the framing FSM; payload bytes go straight to the store.
// The closing byte starts a read-out of PAYLOAD_LEN beats, one per cycle when the
// consumer is ready, through the registered read port; in_ready is low until the last
// beat has moved into the output register. Reset clears the control and output
// registers only; the store is not cleared, as every entry is written before it is read.
`default_nettype none

module header_framed_packet_receiver_core
    import hfpr_pkg::*;
#(
    parameter int PAYLOAD_LEN = PAYLOAD_LEN_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BYTE_W-1:0]  rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [BYTE_W-1:0]  payload_byte,
    output logic      [INDEX_W-1:0] byte_index,
    output logic                    last_of_frame,
    output logic      [SUM_W-1:0]   frame_sum
);

    localparam int CNT_W  = $clog2(PAYLOAD_LEN + 1);
    localparam int ADDR_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
    localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(PAYLOAD_LEN);
    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(PAYLOAD_LEN - 1);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_HDR1,
        ST_RECV,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   ld_idx_reg;
    logic               rd_pend_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  payload_byte_reg;
    logic [INDEX_W-1:0] byte_index_reg;
    logic               last_reg;
    logic [SUM_W-1:0]   frame_sum_reg;

    logic               in_fire;
    logic               wr_en;
    logic               rd_issue;
    logic               out_load;
    logic [BYTE_W-1:0]  rd_data;
    logic [SUM_W-1:0]   sum_add;

    assign in_ready = (state_reg != ST_EMIT);
    assign in_fire  = in_valid && in_ready;
    assign wr_en    = in_fire && (state_reg == ST_RECV) && (count_reg != LEN_C);
    assign out_load = rd_pend_reg && (!out_valid_reg || out_ready);
    assign rd_issue = (state_reg == ST_EMIT) && (rd_idx_reg != LEN_C)
                      && (!rd_pend_reg || out_load);
    assign sum_add  = sum_reg + SUM_W'(rx_byte);

    hfpr_ram #(
        .DEPTH  (PAYLOAD_LEN),
        .WIDTH  (BYTE_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_issue),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_HUNT;
            count_reg        <= '0;
            sum_reg          <= '0;
            rd_idx_reg       <= '0;
            ld_idx_reg       <= '0;
            rd_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            payload_byte_reg <= '0;
            byte_index_reg   <= '0;
            last_reg         <= 1'b0;
            frame_sum_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (in_fire && (rx_byte == HDR_FIRST))
                    begin
                        sum_reg   <= SUM_W'(rx_byte);
                        state_reg <= ST_HDR1;
                    end
                end
                ST_HDR1:
                begin
                    if (in_fire)
                    begin
                        if (rx_byte == HDR_SECOND)
                        begin
                            sum_reg   <= sum_add;
                            count_reg <= '0;
                            state_reg <= ST_RECV;
                        end
                        else
                        begin
                            state_reg <= ST_HUNT;
                        end
                    end
                end
                ST_RECV:
                begin
                    if (in_fire)
                    begin
                        if (count_reg != LEN_C)
                        begin
                            sum_reg   <= sum_add;
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            rd_idx_reg <= '0;
                            ld_idx_reg <= '0;
                            state_reg  <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (rd_issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (out_load)
                    begin
                        ld_idx_reg <= ld_idx_reg + 1'b1;
                    end
                    if ((rd_idx_reg == LEN_C) && !rd_pend_reg)
                    begin
                        state_reg <= ST_HUNT;
                    end
                end
                default:
                begin
                    state_reg <= ST_HUNT;
                end
            endcase

            // hold the read data until it moves into the output register
            if (rd_issue)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                rd_pend_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg    <= 1'b1;
                payload_byte_reg <= rd_data;
                byte_index_reg   <= INDEX_W'(ld_idx_reg);
                last_reg         <= (ld_idx_reg == LAST_C);
                frame_sum_reg    <= sum_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign payload_byte  = payload_byte_reg;
    assign byte_index    = byte_index_reg;
    assign last_of_frame = last_reg;
    assign frame_sum     = frame_sum_reg;

endmodule

`default_nettype wire

[bench/frame_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the header-framed packet receiver: tracks framing and predicts every beat.
// Depends on hfpr_pkg for the byte, index and sum widths and the header values.

package frame_scoreboard_pkg;

    import hfpr_pkg::*;

    typedef enum logic [1:0] {
        SEEK_SYNC1,
        SEEK_SYNC2,
        FILL_PAYLOAD
    } rx_phase_e;

    typedef struct {
        logic [BYTE_W-1:0]  payload_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last_of_frame;
        logic [SUM_W-1:0]   frame_sum;
    } frame_beat_t;

    class frame_scoreboard;

        rx_phase_e          phase;
        int unsigned        fill_count;
        logic [SUM_W-1:0]   frame_total;
        logic [BYTE_W-1:0]  held_payload [PAYLOAD_LEN_DEF];
        frame_beat_t        expected_beats [$];
        int unsigned        errors;

        function new();
            phase       = SEEK_SYNC1;
            fill_count  = 0;
            frame_total = '0;
            errors      = 0;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] rx);
            frame_beat_t beat;
            case (phase)
                SEEK_SYNC2:
                begin
                    if (rx == HDR_SECOND)
                    begin
                        frame_total = frame_total + rx;
                        fill_count  = 0;
                        phase       = FILL_PAYLOAD;
                    end
                    else
                    begin
                        phase = SEEK_SYNC1;
                    end
                end
                FILL_PAYLOAD:
                begin
                    if (fill_count < PAYLOAD_LEN_DEF)
                    begin
                        frame_total              = frame_total + rx;
                        held_payload[fill_count] = rx;
                        fill_count++;
                    end
                    else
                    begin
                        // closing byte: discard it and release the whole frame
                        for (int i = 0; i < PAYLOAD_LEN_DEF; i++)
                        begin
                            beat.payload_byte  = held_payload[i];
                            beat.byte_index    = INDEX_W'(i);
                            beat.last_of_frame = (i == PAYLOAD_LEN_DEF - 1);
                            beat.frame_sum     = frame_total;
                            expected_beats.push_back(beat);
                        end
                        phase = SEEK_SYNC1;
                    end
                end
                default:
                begin
                    if (rx == HDR_FIRST)
                    begin
                        frame_total = SUM_W'(rx);
                        phase       = SEEK_SYNC2;
                    end
                    else
                    begin
                        phase = SEEK_SYNC1;
                    end
                end
            endcase
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [BYTE_W-1:0] payload_byte, logic [INDEX_W-1:0] byte_index,
                                 logic last_of_frame, logic [SUM_W-1:0] frame_sum);
            frame_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("unexpected output beat: payload_byte %0d, byte_index %0d",
                       payload_byte, byte_index);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("payload_byte", want.payload_byte, payload_byte);
            compare_field("byte_index", want.byte_index, byte_index);
            compare_field("last_of_frame", want.last_of_frame, last_of_frame);
            compare_field("frame_sum", want.frame_sum, frame_sum);
        endfunction

    endclass

endpackage

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the bench: clock, reset, byte source with bursts and gaps, stalling sink, watchdog.
// Depends on hfpr_pkg, frame_scoreboard_pkg and header_framed_packet_receiver_core.

module testbench;

    import hfpr_pkg::*;
    import frame_scoreboard_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 350;
    localparam int DRAIN_CYCLES   = PAYLOAD_LEN_DEF + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [BYTE_W-1:0]  rx_byte   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BYTE_W-1:0]  payload_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last_of_frame;
    logic [SUM_W-1:0]   frame_sum;

    frame_scoreboard sb;
    int              burst_left  = 0;
    int              bytes_sent  = 0;
    int              idle_cycles = 0;
    logic [5:0]      stall_tick  = '0;
    int              stall_mode  = 0;

    always #CLK_HALF clk = ~clk;

    header_framed_packet_receiver_core #(
        .PAYLOAD_LEN(PAYLOAD_LEN_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last_of_frame(last_of_frame),
        .frame_sum    (frame_sum)
    );

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return HDR_FIRST;
            3:       return HDR_SECOND;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame();
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        repeat (PAYLOAD_LEN_DEF)
            send_byte(pick_byte());
        send_byte(pick_byte());
    endtask

    // sink: check each beat, then pick the next ready level from the current stall mode
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(payload_byte, byte_index, last_of_frame, frame_sum);
        stall_tick = stall_tick + 1'b1;
        if (stall_tick == '0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_tick[2];
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] wrong;
        int                target;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // noise, a lone second header byte, a bad second header byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(8'h41);
        // repeated first header byte must not restart the header
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        // full frame at the largest sum, closed by a header-valued byte
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        repeat (PAYLOAD_LEN_DEF)
            send_byte(8'hFF);
        send_byte(HDR_FIRST);

        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            case ($urandom_range(0, 9))
                7:
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                8:
                begin
                    wrong = pick_byte();
                    if (wrong == HDR_SECOND)
                        wrong = wrong ^ 8'h01;
                    send_byte(HDR_FIRST);
                    send_byte(wrong);
                end
                9:
                begin
                    send_byte(HDR_FIRST);
                    send_byte(HDR_FIRST);
                end
                default:
                    send_frame();
            endcase
        end
        in_valid <= 1'b0;

        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
